// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- src/olie_pkg.sv -----
// ----------------------------------------------------------------------------
// olie_pkg
// shared types and constants of the ordered list insert engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olie_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 16;
  localparam int POS_W      = 6;

  typedef enum logic [1:0] {
    OP_FRONT   = 2'd0,
    OP_BACK    = 2'd1,
    OP_ORDERED = 2'd2,
    OP_DUMP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FILL,
    ST_DUMP,
    ST_RESP
  } state_e;

  typedef logic [ADDR_W-1:0] addr_t;

  // circular buffer: physical slot of a logical index from the head
  function automatic addr_t phys_addr(input addr_t base, input addr_t idx);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= (ADDR_W + 1)'(LIST_DEPTH)) begin
      s = s - (ADDR_W + 1)'(LIST_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/ordered_list_insert_engine_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_engine_unit
// bounded list of signed values with head, tail and ordered insert and dump
// ----------------------------------------------------------------------------
// input channel: operation_i and value_i, taken when in_valid_i is high and
// in_stall_o is low. the engine works on one transaction at a time and
// holds in_stall_o high until its last result is in the output register.
// output channel: entry_value_o, position_o, status_o, last_o, handed over
// when out_valid_o is high and out_stall_i is low. one output register
// decouples the two sides; a stalled result holds its payload.
// steps per transaction, set by the single ram read port:
//   insert at head or tail: ram write, then result; insert into a full list: result only
//   ordered insert: compare from the head until the slot is found, shift the
//   entries from the tail down to the slot up by one, write, then result;
//   no shift when it lands at the tail, straight to the write into an empty list
//   dump: one entry per cycle while out_stall_i is low, empty dump one result
// a result waiting on out_stall_i holds the engine in place.
// the list lives in a circular buffer, so head inserts need no shifting.
// reset empties the list at once; the ram contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ordered_list_insert_engine_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         operation_i,
  input  wire logic signed [olie_pkg::VAL_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [olie_pkg::VAL_W-1:0]       entry_value_o,
  output logic [olie_pkg::POS_W-1:0]              position_o,
  output logic [1:0]                              status_o,
  output logic                                    last_o
);

  import olie_pkg::*;

  state_e                  state_q, state_d;
  addr_t                   head_q, head_d;
  logic [CNT_W-1:0]        count_q, count_d;
  addr_t                   idx_q, idx_d;
  addr_t                   slot_q, slot_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  status_e                 res_st_q, res_st_d;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_val_q, out_val_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;
  status_e                 out_st_q, out_st_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load, out_free;

  logic                    ram_we, ram_re;
  addr_t                   ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_wdata, ram_rdata;

  logic                    full;
  addr_t                   cnt_addr, cnt_m1, head_dec;
  logic [CNT_W-1:0]        idx_ext, idx_inc;
  op_e                     op;

  olie_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign op       = op_e'(operation_i);
  assign full     = (count_q == CNT_W'(LIST_DEPTH));
  assign cnt_addr = count_q[ADDR_W-1:0];
  assign cnt_m1   = cnt_addr - addr_t'(1);
  assign head_dec = (head_q == '0) ? addr_t'(LIST_DEPTH - 1) : head_q - addr_t'(1);
  assign idx_ext  = CNT_W'(idx_q);
  assign idx_inc  = idx_ext + CNT_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    val_d      = val_q;
    res_st_d   = res_st_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = val_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    out_load   = 1'b0;
    out_val_d  = val_q;
    out_pos_d  = '0;
    out_st_d   = res_st_q;
    out_last_d = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          res_st_d = STAT_OK;
          if (op == OP_DUMP) begin
            if (count_q == '0) begin
              val_d    = '0;
              res_st_d = STAT_EMPTY;
              state_d  = ST_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              idx_d     = '0;
              state_d   = ST_DUMP;
            end
          end else if (full) begin
            res_st_d = STAT_FULL;
            state_d  = ST_RESP;
          end else begin
            case (op)
              OP_FRONT: begin
                head_d    = head_dec;
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                ram_wdata = value_i;
                count_d   = count_q + CNT_W'(1);
                state_d   = ST_RESP;
              end
              OP_BACK: begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr(head_q, cnt_addr);
                ram_wdata = value_i;
                count_d   = count_q + CNT_W'(1);
                state_d   = ST_RESP;
              end
              default: begin
                if (count_q == '0) begin
                  slot_d  = '0;
                  state_d = ST_FILL;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_q;
                  idx_d     = '0;
                  state_d   = ST_SCAN;
                end
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (val_q <= $signed(ram_rdata)) begin
          // slot found, start moving the tail up by one
          slot_d    = idx_q;
          ram_re    = 1'b1;
          ram_raddr = phys_addr(head_q, cnt_m1);
          idx_d     = cnt_addr;
          state_d   = ST_SHIFT;
        end else if (idx_inc == count_q) begin
          slot_d  = cnt_addr;
          state_d = ST_FILL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys_addr(head_q, idx_q + addr_t'(1));
          idx_d     = idx_q + addr_t'(1);
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = phys_addr(head_q, idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_q - addr_t'(1);
        if (idx_q - addr_t'(1) == slot_q) begin
          state_d = ST_FILL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys_addr(head_q, idx_q - addr_t'(2));
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = phys_addr(head_q, slot_q);
        ram_wdata = val_q;
        count_d   = count_q + CNT_W'(1);
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val_d  = $signed(ram_rdata);
          out_pos_d  = POS_W'(idx_q);
          out_st_d   = STAT_OK;
          out_last_d = (idx_inc == count_q);
          if (idx_inc == count_q) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys_addr(head_q, idx_q + addr_t'(1));
            idx_d     = idx_q + addr_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    val_q    <= val_d;
    res_st_q <= res_st_d;
    if (out_load) begin
      out_val_q  <= out_val_d;
      out_pos_q  <= out_pos_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_val_q;
  assign position_o    = out_pos_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(LIST_DEPTH))
  `ASSERT_PROP(a_count_step, clk_i, rst_ni,
               (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
  `ASSERT_PROP(a_shift_above_slot, clk_i, rst_ni, (state_q == ST_SHIFT) |-> (idx_q > slot_q))
  `ASSERT_PROP(a_walk_in_list, clk_i, rst_ni,
               (state_q == ST_DUMP || state_q == ST_SCAN) |-> (idx_ext < count_q))
  `ASSERT_PROP(a_no_load_over_held, clk_i, rst_ni, (out_valid_q && out_stall_i) |-> !out_load)

endmodule

`default_nettype wire

// ----- src/olie_ram.sv -----
// ----------------------------------------------------------------------------
// olie_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_ordered_list_insert_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_engine_unit
// self-checking bench for the ordered list insert engine: a queue-based copy
// of the list predicts every result of head, tail and ordered inserts and of
// dumps, and each result from the block is compared field by field against
// it. both channels idle and stall at random, with one back-to-back stretch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_insert_engine_unit;

  import olie_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * LIST_DEPTH + 40;

  typedef struct {
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        position;
    status_e                 status;
    logic                    last;
  } list_result_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              operation_i = 2'd0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] entry_value_o;
  logic [POS_W-1:0]        position_o;
  logic [1:0]              status_o;
  logic                    last_o;

  logic signed [VAL_W-1:0] list_model_q[$];
  list_result_t            expected_results_q[$];
  int                      error_count = 0;
  int                      quiet_cycles = 0;
  bit                      no_idling = 1'b0;

  ordered_list_insert_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_value_o (entry_value_o),
    .position_o    (position_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic push_result(input logic signed [VAL_W-1:0] v, input int pos,
                             input status_e st, input logic fin);
    list_result_t r;
    r.entry_value = v;
    r.position    = POS_W'(pos);
    r.status      = st;
    r.last        = fin;
    expected_results_q.push_back(r);
  endtask

  // list behavior for one accepted transaction
  task automatic predict_list_op(input op_e op, input logic signed [VAL_W-1:0] v);
    int slot;
    if (op == OP_DUMP) begin
      if (list_model_q.size() == 0) begin
        push_result('0, 0, STAT_EMPTY, 1'b1);
      end else begin
        foreach (list_model_q[i]) begin
          push_result(list_model_q[i], i, STAT_OK, i == list_model_q.size() - 1);
        end
      end
    end else if (list_model_q.size() >= LIST_DEPTH) begin
      push_result(v, 0, STAT_FULL, 1'b1);
    end else begin
      case (op)
        OP_FRONT: begin
          list_model_q.push_front(v);
        end
        OP_BACK: begin
          list_model_q.push_back(v);
        end
        default: begin
          slot = list_model_q.size();
          for (int i = 0; i < list_model_q.size(); i++) begin
            if (v <= list_model_q[i]) begin
              slot = i;
              break;
            end
          end
          list_model_q.insert(slot, v);
        end
      endcase
      push_result(v, 0, STAT_OK, 1'b1);
    end
  endtask

  task automatic send_item(input op_e op, input logic signed [VAL_W-1:0] v);
    if (!no_idling) begin
      while ($urandom_range(99) < 35) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_list_op(op, v);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results_q.size() != 0);
  endtask

  // extremes, small values for duplicates, or anything
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return (r < 5) ? 16'sh8000 : 16'sh7fff;
    if (r < 40) return VAL_W'($signed($urandom_range(8)) - 4);
    return VAL_W'($urandom);
  endfunction

  function automatic op_e pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 20) return OP_FRONT;
    if (r < 40) return OP_BACK;
    if (r < 85) return OP_ORDERED;
    return OP_DUMP;
  endfunction

  task automatic test_empty_list();
    send_item(OP_DUMP, pick_value());
    send_item(OP_ORDERED, 16'sd7);
    send_item(OP_DUMP, pick_value());
  endtask

  task automatic test_each_operation();
    send_item(OP_FRONT, 16'sh7fff);
    send_item(OP_BACK, 16'sh8000);
    send_item(OP_ORDERED, 16'sh8000);
    send_item(OP_ORDERED, 16'sd7);
    send_item(OP_ORDERED, 16'sh7fff);
    send_item(OP_ORDERED, 16'sd3);
    send_item(OP_BACK, -16'sd1);
    send_item(OP_FRONT, 16'sd0);
    send_item(OP_ORDERED, 16'sh5555);
    send_item(OP_FRONT, 16'shaaaa);
    send_item(OP_DUMP, 16'shffff);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_item(pick_op(), pick_value());
  endtask

  task automatic test_back_to_back();
    no_idling = 1'b1;
    test_random_mix(20);
    no_idling = 1'b0;
  endtask

  task automatic test_full_list();
    while (list_model_q.size() < LIST_DEPTH) begin
      send_item(op_e'($urandom_range(2)), pick_value());
    end
    send_item(OP_FRONT, 16'sh8000);
    send_item(OP_BACK, 16'sh7fff);
    send_item(OP_ORDERED, 16'sd0);
    send_item(OP_DUMP, pick_value());
  endtask

  // result checker
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results_q.size() == 0) begin
        report_mismatch("result with none expected", int'(entry_value_o), 0);
      end else begin
        want = expected_results_q.pop_front();
        if (entry_value_o !== want.entry_value)
          report_mismatch("entry_value", int'(entry_value_o), int'(want.entry_value));
        if (position_o !== want.position)
          report_mismatch("position", int'(position_o), int'(want.position));
        if (status_o !== want.status)
          report_mismatch("status", int'(status_o), int'(want.status));
        if (last_o !== want.last)
          report_mismatch("last", int'(last_o), int'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !no_idling && ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_each_operation();
    test_random_mix(20);
    wait_results_done();
    test_back_to_back();
    test_full_list();
    test_random_mix(55);
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results_q.size() != 0) begin
      report_mismatch("results missing at end", 0, expected_results_q.size());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/olie_pkg.sv
src/olie_ram.sv
src/ordered_list_insert_engine_unit.sv
sim/tb_ordered_list_insert_engine_unit.sv
